// ----- design/dsp_pkg.sv -----
// Package of shared types and constants for the duration string parser.
`timescale 1ns / 1ps
`default_nettype none

package dsp_pkg;

	// Width of the period field on the result channel.
	localparam int PERIOD_W = 64;

	// Width of the constant seconds table entries.
	localparam int SEC_W = 24;

	// Seconds per unit for week, day, hour and minute, in that order.
	localparam logic [SEC_W-1:0] SEC_TAB [4] = '{
		SEC_W'(60 * 60 * 24 * 7),
		SEC_W'(60 * 60 * 24),
		SEC_W'(60 * 60),
		SEC_W'(60)
	};

	// Character codes.
	localparam logic [7:0] CH_END   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_W     = 8'h77;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_M     = 8'h6d;
	localparam logic [7:0] CH_S     = 8'h73;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_PARSE = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN  = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	// Unit codes in the order they must appear.
	typedef enum logic [2:0] {
		U_NONE = 3'd0,
		U_W    = 3'd1,
		U_D    = 3'd2,
		U_H    = 3'd3,
		U_M    = 3'd4,
		U_S    = 3'd5,
		U_END  = 3'd6
	} unit_t;

	// One input item: a character and the start-of-string mark.
	typedef struct packed {
		logic [7:0] ch;
		logic       first;
	} chr_item_t;

	// One result item.
	typedef struct packed {
		status_t                     status;
		logic signed [PERIOD_W-1:0]  period;
	} res_item_t;

	// Map a character to its unit code.
	function automatic unit_t unit_of(input logic [7:0] c);
		unit_t u;
		case (c)
			CH_W: u = U_W;
			CH_D: u = U_D;
			CH_H: u = U_H;
			CH_M: u = U_M;
			CH_S: u = U_S;
			CH_END: u = U_END;
			default: u = U_NONE;
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

// ----- design/dsp_in_stage.sv -----
// Input register stage that holds one accepted character item.
`timescale 1ns / 1ps
`default_nettype none

module dsp_in_stage
	import dsp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      chr_valid,
	output logic           chr_ready,
	input  wire chr_item_t chr,
	input  wire logic      go,
	output logic           item_valid_s1,
	output chr_item_t      item_s1
);

	// The stage takes a new item when empty or when its item moves on.
	assign chr_ready = !item_valid_s1 || go;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (chr_ready) begin
			item_valid_s1 <= chr_valid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (chr_ready && chr_valid) begin
			item_s1 <= chr;
		end
	end

endmodule

`default_nettype wire

// ----- design/dsp_core.sv -----
// Parser state and the combinational step logic for one character.
`timescale 1ns / 1ps
`default_nettype none

module dsp_core
	import dsp_pkg::*;
#(
	parameter int VW = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	input  wire chr_item_t item,
	input  wire logic      go,
	output logic           res_push,
	output res_item_t      res_item
);

	localparam int NW = VW + 4;
	localparam int PW = VW + SEC_W;

	// Parser state.
	phase_t        phase_q;
	logic          neg_q;
	logic [VW-1:0] total_q;
	logic [VW-1:0] ntotal_q;
	logic [VW-1:0] number_q;
	logic          hd_q;
	unit_t         prev_q;
	logic [VW-1:0] prod_q [4];
	logic          ov_q [4];

	// Next-state values.
	phase_t        phase_d;
	logic          neg_d;
	logic [VW-1:0] total_d;
	logic [VW-1:0] ntotal_d;
	logic [VW-1:0] number_d;
	logic          hd_d;
	unit_t         prev_d;
	logic [VW-1:0] prod_d [4];
	logic          ov_d [4];

	// State as seen by this item; a first character clears it.
	phase_t        e_phase;
	logic [VW-1:0] e_total;
	logic [VW-1:0] e_ntotal;
	logic [VW-1:0] e_number;
	logic          e_hd;
	unit_t         e_prev;
	logic [VW-1:0] e_prod [4];
	logic          e_ov [4];

	logic          sign_start;
	logic          is_digit;
	logic [3:0]    digit;
	unit_t         unit;
	logic [NW-1:0] num_x10;
	logic [VW-1:0] prod_upd [4];
	logic          ov_upd [4];
	logic [VW-1:0] sel_prod;
	logic          sel_ov;
	logic [VW:0]   sum;
	logic [VW-1:0] nsum;
	logic          res_valid;
	status_t       res_status;
	logic [VW-1:0] res_value;
	logic signed [VW-1:0] res_signed;

	assign sign_start = item.first && (item.ch == CH_PLUS || item.ch == CH_MINUS);
	assign is_digit   = (item.ch >= CH_0) && (item.ch <= CH_9);
	assign digit      = 4'(item.ch - CH_0);
	assign unit       = unit_of(item.ch);

	// Effective state for this item.
	always_comb begin
		e_phase  = item.first ? PH_RUN : phase_q;
		e_total  = item.first ? '0 : total_q;
		e_ntotal = item.first ? '0 : ntotal_q;
		e_number = item.first ? '0 : number_q;
		e_hd     = item.first ? 1'b0 : hd_q;
		e_prev   = item.first ? U_NONE : prev_q;
		for (int i = 0; i < 4; i++) begin
			e_prod[i] = item.first ? '0 : prod_q[i];
			e_ov[i]   = item.first ? 1'b0 : ov_q[i];
		end
	end

	// Number times ten plus the new digit, with room to see overflow.
	assign num_x10 = ({4'b0, e_number} << 3) + ({4'b0, e_number} << 1) + NW'(digit);

	// Running products of the number with each unit's seconds, kept
	// alongside the number so a unit only needs a selection.
	for (genvar g = 0; g < 4; g++) begin : g_prod
		logic [PW-1:0] ext;
		assign ext = ({{SEC_W{1'b0}}, e_prod[g]} << 3)
			+ ({{SEC_W{1'b0}}, e_prod[g]} << 1)
			+ PW'(SEC_W'(digit) * SEC_TAB[g]);
		assign prod_upd[g] = ext[VW-1:0];
		assign ov_upd[g]   = e_ov[g] || (|ext[PW-1:VW]);
	end

	// Product of the finished number and its unit.
	always_comb begin
		case (unit)
			U_W: begin
				sel_prod = e_prod[0];
				sel_ov   = e_ov[0];
			end
			U_D: begin
				sel_prod = e_prod[1];
				sel_ov   = e_ov[1];
			end
			U_H: begin
				sel_prod = e_prod[2];
				sel_ov   = e_ov[2];
			end
			U_M: begin
				sel_prod = e_prod[3];
				sel_ov   = e_ov[3];
			end
			default: begin
				sel_prod = e_number;
				sel_ov   = 1'b0;
			end
		endcase
	end

	// The total and its negation are updated side by side.
	assign sum  = {1'b0, e_total} + {1'b0, sel_prod};
	assign nsum = e_ntotal - sel_prod;

	// Result decision for this item.
	always_comb begin
		res_valid  = 1'b0;
		res_status = ST_OK;
		res_value  = '0;
		if (!sign_start && e_phase == PH_RUN) begin
			if (is_digit) begin
				if (|num_x10[NW-1:VW]) begin
					res_valid  = 1'b1;
					res_status = ST_RANGE;
				end
			end else if (!e_hd || unit == U_NONE || unit <= e_prev) begin
				res_valid  = 1'b1;
				res_status = ST_PARSE;
			end else if (sel_ov || sum[VW]) begin
				res_valid  = 1'b1;
				res_status = ST_RANGE;
			end else if (unit == U_S || unit == U_END) begin
				res_valid = 1'b1;
				if (neg_d) begin
					if (sum[VW-1] && (|sum[VW-2:0])) begin
						res_status = ST_RANGE;
					end else begin
						res_value = nsum;
					end
				end else if (sum[VW-1]) begin
					res_status = ST_RANGE;
				end else begin
					res_value = sum[VW-1:0];
				end
			end
		end
	end

	assign neg_d = item.first ? (item.ch == CH_MINUS) : neg_q;

	// Next state for this item.
	always_comb begin
		phase_d  = e_phase;
		total_d  = e_total;
		ntotal_d = e_ntotal;
		number_d = e_number;
		hd_d     = e_hd;
		prev_d   = e_prev;
		for (int i = 0; i < 4; i++) begin
			prod_d[i] = e_prod[i];
			ov_d[i]   = e_ov[i];
		end
		if (!sign_start && e_phase == PH_RUN) begin
			if (res_valid) begin
				phase_d = PH_DONE;
			end else if (is_digit) begin
				number_d = num_x10[VW-1:0];
				hd_d     = 1'b1;
				for (int i = 0; i < 4; i++) begin
					prod_d[i] = prod_upd[i];
					ov_d[i]   = ov_upd[i];
				end
			end else begin
				total_d  = sum[VW-1:0];
				ntotal_d = nsum;
				prev_d   = unit;
				number_d = '0;
				hd_d     = 1'b0;
				for (int i = 0; i < 4; i++) begin
					prod_d[i] = '0;
					ov_d[i]   = 1'b0;
				end
			end
		end
	end

	// State registers advance when the item is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			neg_q    <= 1'b0;
			total_q  <= '0;
			ntotal_q <= '0;
			number_q <= '0;
			hd_q     <= 1'b0;
			prev_q   <= U_NONE;
			for (int i = 0; i < 4; i++) begin
				prod_q[i] <= '0;
				ov_q[i]   <= 1'b0;
			end
		end else if (item_valid && go) begin
			phase_q  <= phase_d;
			neg_q    <= neg_d;
			total_q  <= total_d;
			ntotal_q <= ntotal_d;
			number_q <= number_d;
			hd_q     <= hd_d;
			prev_q   <= prev_d;
			for (int i = 0; i < 4; i++) begin
				prod_q[i] <= prod_d[i];
				ov_q[i]   <= ov_d[i];
			end
		end
	end

	// Result payload, sign-extended to the period width.
	assign res_signed      = res_value;
	assign res_push        = item_valid && res_valid;
	assign res_item.status = res_status;
	assign res_item.period = PERIOD_W'(res_signed);

	// The negated total always tracks the total.
	a_ntotal: assert property (@(posedge clk) disable iff (!arst_n)
		ntotal_q == VW'(0) - total_q)
		else $error("negated total out of step with total");

	// A segment without digits carries no number and no product overflow.
	a_no_digit: assert property (@(posedge clk) disable iff (!arst_n)
		!hd_q |-> (number_q == '0 && !ov_q[0] && !ov_q[1] && !ov_q[2] && !ov_q[3]))
		else $error("number left over without digits");

	// A consumed result moves the parser to the done phase.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && go) |=> phase_q == PH_DONE)
		else $error("parser kept running after a result");

endmodule

`default_nettype wire

// ----- design/dsp_out_stage.sv -----
// Result register that holds one result item until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module dsp_out_stage
	import dsp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire res_item_t res_in,
	output logic           res_valid,
	input  wire logic      res_ready,
	output res_item_t      res,
	output logic           free
);

	// The register can take a result when empty or being drained.
	assign free = !res_valid || res_ready;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (load) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	// Payload of the result register.
	always_ff @(posedge clk) begin
		if (load) begin
			res <= res_in;
		end
	end

endmodule

`default_nettype wire

// ----- design/duration_string_parser.sv -----
// Duration string parser: one character item in, at most one result item per string.
//
// Usage: characters of a string such as "-1w2d3h4m5s" arrive on the chr channel,
// one per item, with chr.first set on the first character of each string. A
// string ends on 's' or on a character code of zero. The res channel gives one
// item per string: status ok with the signed period in seconds, a parse error,
// or a range error; characters after that are ignored until the next first.
// Both channels are valid/ready; an item moves when valid and ready are high.
// Path: an accepted item is processed from the input register, and its
// result is loaded into the result register when that register is free,
// which raises res_valid.
// Throughput: one character item per cycle unless a result waits for a full
// result register; the total and per-unit products are updated by a single
// step of adds and compares between the input and result registers.
// Reset clears the parser to idle and empties both registers. When the
// receiver stalls with a result waiting, items that give no result keep
// flowing; an item that would give a result waits in the input register.
`timescale 1ns / 1ps
`default_nettype none

module duration_string_parser
	import dsp_pkg::*;
#(
	parameter int VALUE_WIDTH = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      chr_valid,
	output logic           chr_ready,
	input  wire chr_item_t chr,
	output logic           res_valid,
	input  wire logic      res_ready,
	output res_item_t      res
);

	logic      item_valid_s1;
	chr_item_t item_s1;
	logic      go;
	logic      res_push;
	res_item_t res_item;
	logic      out_free;

	// Input register.
	dsp_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.chr_valid    (chr_valid),
		.chr_ready    (chr_ready),
		.chr          (chr),
		.go           (go),
		.item_valid_s1(item_valid_s1),
		.item_s1      (item_s1)
	);

	// The held item is consumed unless its result has nowhere to go.
	assign go = item_valid_s1 && (!res_push || out_free);

	// Parser state and step logic.
	dsp_core #(
		.VW(VALUE_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid_s1),
		.item      (item_s1),
		.go        (go),
		.res_push  (res_push),
		.res_item  (res_item)
	);

	// Result register.
	dsp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (go && res_push),
		.res_in   (res_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.free     (out_free)
	);

	// A stalled item in the input register holds its payload.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid_s1 && !go) |=> (item_valid_s1 && $stable(item_s1)))
		else $error("input register changed while stalled");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |-> !(go && res_push))
		else $error("result register overwritten while waiting");

endmodule

`default_nettype wire
